[design/fixed_step_object_integrator_unit_assert.svh]
// Assertion macros shared by the integrator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FIXED_STEP_OBJECT_INTEGRATOR_UNIT_ASSERT_SVH
`define FIXED_STEP_OBJECT_INTEGRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSOI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSOI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fsoi_pkg.sv]
`default_nettype none

package fsoi_pkg;

  // Table size default.
  localparam int SLOTS_DEF = 64;

  // Field widths.
  localparam int ACT_W     = 2;
  localparam int SID_W     = 6;
  localparam int POS_W     = 32;
  localparam int STEP_W    = 21;
  localparam int STEP_FRAC = 20;
  localparam int ELAPSED_W = 24;
  localparam int BANK_W    = 25;
  localparam int ST_W      = 2;
  localparam int ACNT_W    = 7;

  localparam logic [STEP_W-1:0] STEP_RESET = 21'd17476;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ADD     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd3;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL       = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_ACTIVE = 2'd2;

  // One input word.
  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [SID_W-1:0]        slot_id;
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic signed [POS_W-1:0] speed_x;
    logic signed [POS_W-1:0] speed_y;
    logic [ELAPSED_W-1:0]    elapsed;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [SID_W-1:0]        slot_used;
    logic signed [POS_W-1:0] read_x;
    logic signed [POS_W-1:0] read_y;
    logic [BANK_W-1:0]       steps_taken;
    logic [ACNT_W-1:0]       active_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            capture;
    logic            scan_clr;
    logic            scan_inc;
    logic            add_commit;
    logic            remove_commit;
    logic            div_start;
    logic            bank_load;
    logic            sweep_issue;
    logic            read_issue;
    logic            emit;
    logic [ST_W-1:0] status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic scan_free;
    logic scan_last;
    logic slot_ok;
    logic div_busy;
    logic steps_zero;
    logic pipe_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

[design/fsoi_div.sv]
`default_nettype none

// Restoring divider: one quotient bit per cycle.
module fsoi_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [fsoi_pkg::BANK_W-1:0] dividend,
  input  wire logic [fsoi_pkg::STEP_W-1:0] divisor,
  output logic                             busy,
  output logic [fsoi_pkg::BANK_W-1:0]      quotient,
  output logic [fsoi_pkg::STEP_W-1:0]      remainder
);

  localparam int BW = fsoi_pkg::BANK_W;
  localparam int SW = fsoi_pkg::STEP_W;
  localparam int CW = $clog2(BW);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [BW-1:0] quo_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] dvs_r;
  logic [SW:0]   trial;
  logic          ge;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_r, quo_r[BW-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(BW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Shift register holds the dividend and collects the quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[BW-2:0], ge};
      rem_r <= ge ? SW'(trial - {1'b0, dvs_r}) : SW'(trial);
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[design/fsoi_dp.sv]
`default_nettype none

// Datapath: slot tables, flags, time bank, divider and the update pipeline.
module fsoi_dp #(
  parameter int SLOTS = fsoi_pkg::SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fsoi_pkg::in_word_t          in_word,
  input  wire fsoi_pkg::ctrl_cmd_t         cmd,
  input  wire logic                        cfg_we,
  input  wire logic [fsoi_pkg::STEP_W-1:0] cfg_data,
  output fsoi_pkg::dp_stat_t               stat,
  output fsoi_pkg::out_word_t              out_word,
  output logic                             out_strobe
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int PW    = fsoi_pkg::POS_W;
  localparam int SW    = fsoi_pkg::STEP_W;
  localparam int BW    = fsoi_pkg::BANK_W;
  localparam int FR    = fsoi_pkg::STEP_FRAC;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  fsoi_pkg::in_word_t  word_r;
  fsoi_pkg::out_word_t out_r;
  logic                out_strobe_r;

  logic [SW-1:0]    step_r;
  logic [SW-1:0]    step_eff;
  logic [BW-1:0]    bank_r;
  logic [BW-1:0]    dividend;
  logic [CNT_W-1:0] count_r;
  logic [SLOTS-1:0] occ_r;
  logic [IDX_W-1:0] scan_r;
  logic [IDX_W-1:0] sid_idx;
  logic             sid_in_range;

  logic             div_busy;
  logic [BW-1:0]    quot;
  logic [SW-1:0]    rem;

  // Slot tables, x in the upper half and y in the lower half.
  logic [2*PW-1:0]  place_mem [SLOTS];
  logic [2*PW-1:0]  rate_mem  [SLOTS];
  logic [2*PW-1:0]  place_rd_r;
  logic [2*PW-1:0]  rate_rd_r;
  logic             pm_we;
  logic [IDX_W-1:0] pm_wa;
  logic [2*PW-1:0]  pm_wd;
  logic             pm_re;
  logic [IDX_W-1:0] pm_ra;

  // Update pipeline.
  logic                    v0_r, v1_r, v2_r;
  logic [IDX_W-1:0]        a0_r, a1_r, a2_r;
  logic signed [PW+SW:0]   prod_x, prod_y;
  logic [PW-1:0]           dx_r, dy_r;
  logic [2*PW-1:0]         p1_r, p2_r;
  logic [PW-1:0]           ex, ey;
  logic [PW-1:0]           ex_r, ey_r;

  // Step length register; a zero step behaves as a step of one LSB.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= fsoi_pkg::STEP_RESET;
    end else if (cfg_we) begin
      step_r <= cfg_data;
    end
  end

  assign step_eff = (step_r == '0) ? SW'(1) : step_r;

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_r <= in_word;
    end
  end

  assign sid_idx      = IDX_W'(word_r.slot_id);
  assign sid_in_range = (32'(word_r.slot_id) < 32'(SLOTS));

  // Scan counter for the free-slot search and the sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.scan_inc || cmd.sweep_issue) begin
      scan_r <= scan_r + 1'b1;
    end
  end

  // Active flags and live count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      count_r <= '0;
    end else if (cmd.add_commit) begin
      occ_r[scan_r] <= 1'b1;
      count_r       <= count_r + 1'b1;
    end else if (cmd.remove_commit) begin
      occ_r[sid_idx] <= 1'b0;
      count_r        <= count_r - 1'b1;
    end
  end

  // Time bank: the divider takes bank plus elapsed, the remainder goes back.
  assign dividend = bank_r + BW'(in_word.elapsed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= '0;
    end else if (cmd.bank_load) begin
      bank_r <= BW'(rem);
    end
  end

  fsoi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (step_eff),
    .busy      (div_busy),
    .quotient  (quot),
    .remainder (rem)
  );

  // Position table ports: add and sweep write, read and sweep read.
  assign pm_we = cmd.add_commit || v2_r;
  assign pm_wa = cmd.add_commit ? scan_r : a2_r;
  assign pm_wd = cmd.add_commit ? {word_r.start_x, word_r.start_y}
                                : {p2_r[2*PW-1:PW] + ex_r, p2_r[PW-1:0] + ey_r};
  assign pm_re = cmd.sweep_issue || cmd.read_issue;
  assign pm_ra = cmd.sweep_issue ? scan_r : sid_idx;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      place_mem[pm_wa] <= pm_wd;
    end
    if (pm_re) begin
      place_rd_r <= place_mem[pm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      rate_mem[scan_r] <= {word_r.speed_x, word_r.speed_y};
    end
    if (cmd.sweep_issue) begin
      rate_rd_r <= rate_mem[scan_r];
    end
  end

  // Stage one: velocity times step, arithmetic shift by the fraction bits.
  assign prod_x = $signed(rate_rd_r[2*PW-1:PW]) * $signed({1'b0, step_eff});
  assign prod_y = $signed(rate_rd_r[PW-1:0]) * $signed({1'b0, step_eff});

  // Stage two: per-step delta times the step count, modulo the word size.
  assign ex = dx_r * PW'(quot);
  assign ey = dy_r * PW'(quot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= cmd.sweep_issue && occ_r[scan_r];
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    a0_r <= scan_r;
    a1_r <= a0_r;
    a2_r <= a1_r;
    dx_r <= prod_x[FR+PW-1:FR];
    dy_r <= prod_y[FR+PW-1:FR];
    p1_r <= place_rd_r;
    p2_r <= p1_r;
    ex_r <= ex;
    ey_r <= ey;
  end

  // Result word, composed once every update has landed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status       <= cmd.status;
      out_r.slot_used    <= '0;
      out_r.read_x       <= '0;
      out_r.read_y       <= '0;
      out_r.steps_taken  <= '0;
      out_r.active_count <= fsoi_pkg::ACNT_W'(count_r);
      unique case (word_r.action)
        fsoi_pkg::ACT_ADD: begin
          if (cmd.status == fsoi_pkg::ST_OK) begin
            out_r.slot_used <= fsoi_pkg::SID_W'(scan_r);
          end
        end
        fsoi_pkg::ACT_REMOVE: begin
          out_r.slot_used <= word_r.slot_id;
        end
        fsoi_pkg::ACT_ADVANCE: begin
          out_r.steps_taken <= quot;
        end
        fsoi_pkg::ACT_READ: begin
          out_r.slot_used <= word_r.slot_id;
          if (cmd.status == fsoi_pkg::ST_OK) begin
            out_r.read_x <= place_rd_r[2*PW-1:PW];
            out_r.read_y <= place_rd_r[PW-1:0];
          end
        end
      endcase
    end
  end

  assign out_word   = out_r;
  assign out_strobe = out_strobe_r;

  // Status to the controller.
  assign stat.full       = (count_r == FULL_CNT);
  assign stat.scan_free  = !occ_r[scan_r];
  assign stat.scan_last  = (scan_r == LAST_IDX);
  assign stat.slot_ok    = sid_in_range && occ_r[sid_idx];
  assign stat.div_busy   = div_busy;
  assign stat.steps_zero = (quot == '0);
  assign stat.pipe_busy  = v0_r || v1_r || v2_r;

endmodule

`default_nettype wire

[design/fsoi_ctrl.sv]
`default_nettype none

// Controller: sequences each action through the datapath.
module fsoi_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [fsoi_pkg::ACT_W-1:0] in_action,
  input  wire fsoi_pkg::dp_stat_t         stat,
  output fsoi_pkg::ctrl_cmd_t             cmd,
  output logic                            busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_REM   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                state_r, state_nxt;
  logic [fsoi_pkg::ST_W-1:0] status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= fsoi_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    cmd.status = status_r;
    state_nxt  = state_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          unique case (in_action)
            fsoi_pkg::ACT_ADD: begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_ADD;
            end
            fsoi_pkg::ACT_REMOVE: begin
              state_nxt = S_REM;
            end
            fsoi_pkg::ACT_ADVANCE: begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
            fsoi_pkg::ACT_READ: begin
              state_nxt = S_READ;
            end
          endcase
        end
      end
      S_ADD: begin
        priority if (stat.full) begin
          status_nxt = fsoi_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else if (stat.scan_free) begin
          cmd.add_commit = 1'b1;
          status_nxt     = fsoi_pkg::ST_OK;
          state_nxt      = S_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_REM: begin
        if (stat.slot_ok) begin
          cmd.remove_commit = 1'b1;
          status_nxt        = fsoi_pkg::ST_OK;
        end else begin
          status_nxt = fsoi_pkg::ST_NOT_ACTIVE;
        end
        state_nxt = S_DONE;
      end
      S_READ: begin
        if (stat.slot_ok) begin
          cmd.read_issue = 1'b1;
          status_nxt     = fsoi_pkg::ST_OK;
        end else begin
          status_nxt = fsoi_pkg::ST_NOT_ACTIVE;
        end
        state_nxt = S_DONE;
      end
      S_DIV: begin
        status_nxt = fsoi_pkg::ST_OK;
        if (!stat.div_busy) begin
          cmd.bank_load = 1'b1;
          if (stat.steps_zero) begin
            state_nxt = S_DONE;
          end else begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

[design/fixed_step_object_integrator_unit.sv]
// Each accepted word is answered with one out_strobe. An advance runs the divider and, when
// at least one whole step is due, sweeps the table one slot per cycle through a 3-stage
// multiply pipeline. The unit takes no new word until the last result is out, as busy
// falls in the out_strobe cycle and the next start is taken in that same cycle.
// Reset (rst_n low, synchronous) clears all active flags, the count and the time bank,
// and reloads the step length; results are never held off by the receiver.
`default_nettype none

`include "fixed_step_object_integrator_unit_assert.svh"

module fixed_step_object_integrator_unit #(
  parameter int SLOTS = fsoi_pkg::SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire fsoi_pkg::in_word_t          in_word,
  output logic                             out_strobe,
  output fsoi_pkg::out_word_t              out_word,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fsoi_pkg::STEP_W-1:0] cfg_data
);

  fsoi_pkg::ctrl_cmd_t cmd;
  fsoi_pkg::dp_stat_t  stat;

  // The step register can take a word in any cycle.
  assign cfg_ready = 1'b1;

  fsoi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_word.action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  fsoi_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .out_word   (out_word),
    .out_strobe (out_strobe)
  );

  // Checks on sequencing.
  `FSOI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `FSOI_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held too long")
  `FSOI_ASSERT_NOW(a_emit_drained, cmd.emit, !stat.pipe_busy, "result before updates landed")
  `FSOI_ASSERT_NOW(a_add_not_full, cmd.add_commit, !stat.full, "add committed on a full table")

endmodule

`default_nettype wire
